/* design/csp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, name tables and helper functions for the color string parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int NUM_NAMES = 9;
  localparam int NAME_CHARS = 11;
  localparam int PREFIX_CHARS = 9;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_NAME,
    MODE_HASH,
    MODE_ZERO,
    MODE_HEX,
    MODE_PREFIX,
    MODE_DEAD
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_NAME  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_DIGIT = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  pos;     // saturates at 31
    logic [3:0]  digits;  // saturates at 15
    logic [31:0] acc;
    logic [8:0]  cand;
    logic        exact;
    logic        bad;
  } parse_state_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] color;
  } name_hit_t;

  localparam logic [4:0] POS_MAX    = 5'd31;
  localparam logic [3:0] DIGITS_MAX = 4'd15;
  localparam logic [8:0] CAND_ALL   = 9'h1FF;
  localparam logic [8:0] CAND_BARE  = 9'h0FF;  // no transparent without prefix
  localparam logic [4:0] EXACT_LEN  = 5'd11;
  localparam logic [4:0] PREFIX_LEN = 5'd9;

  // Names padded with spaces to 11 chars; length check guards the padding.
  localparam logic [8*NAME_CHARS-1:0] NAME_TEXT [NUM_NAMES] = '{
    "red        ", "green      ", "blue       ", "black      ", "white      ",
    "cyan       ", "magenta    ", "yellow     ", "transparent"
  };
  localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{
    5'd3, 5'd5, 5'd4, 5'd5, 5'd5, 5'd4, 5'd7, 5'd6, 5'd11
  };
  localparam logic [31:0] NAME_COLOR [NUM_NAMES] = '{
    32'hFFFF0000, 32'hFF00FF00, 32'hFF0000FF, 32'hFF000000, 32'hFFFFFFFF,
    32'hFF00FFFF, 32'hFFFF00FF, 32'hFFFFFF00, 32'h00000000
  };

  // Namespace prefix: '#', platform tag, ':' (lowercase).
  localparam logic [8*PREFIX_CHARS-1:0] NS_PREFIX = {
    8'h23, 8'h61, 8'h6E, 8'h64, 8'h72, 8'h6F, 8'h69, 8'h64, 8'h3A
  };
  localparam logic [8*NAME_CHARS-1:0] EXACT_TEXT = "transparent";

  function automatic logic [7:0] char_at11(logic [8*NAME_CHARS-1:0] s, logic [3:0] k);
    logic [8*NAME_CHARS-1:0] t;
    t = s << {k, 3'b000};
    return t[8*NAME_CHARS-1 -: 8];
  endfunction

  function automatic logic [7:0] char_at9(logic [8*PREFIX_CHARS-1:0] s, logic [3:0] k);
    logic [8*PREFIX_CHARS-1:0] t;
    t = s << {k, 3'b000};
    return t[8*PREFIX_CHARS-1 -: 8];
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Drop every candidate whose character at k differs from c.
  function automatic logic [8:0] filter_names(logic [8:0] cand, logic [4:0] k,
                                              logic [7:0] c);
    logic [8:0] keep;
    for (int i = 0; i < NUM_NAMES; i++) begin
      keep[i] = cand[i] && (k < NAME_LEN[i]) && (char_at11(NAME_TEXT[i], k[3:0]) == c);
    end
    return keep;
  endfunction

  // Lowest-index candidate whose length equals count.
  function automatic name_hit_t find_name(logic [8:0] cand, logic [4:0] count);
    name_hit_t r;
    r.hit = 1'b0;
    r.color = '0;
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      if (cand[i] && NAME_LEN[i] == count) begin
        r.hit = 1'b1;
        r.color = NAME_COLOR[i];
      end
    end
    return r;
  endfunction

  function automatic parse_state_t reset_state();
    parse_state_t s;
    s.mode = MODE_START;
    s.pos = '0;
    s.digits = '0;
    s.acc = '0;
    s.cand = CAND_ALL;
    s.exact = 1'b1;
    s.bad = 1'b0;
    return s;
  endfunction

endpackage

/* design/csp_char_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_char_if
// Character stream channel: one string byte per beat.
// ----------------------------------------------------------------------------
interface csp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       last;

  modport source (output valid, output char_code, output char_present,
                  output last, input ready);
  modport sink (input valid, input char_code, input char_present,
                input last, output ready);
endinterface

/* design/csp_color_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_color_if
// Result channel: one parsed color and status per beat.
// ----------------------------------------------------------------------------
interface csp_color_if;
  logic        valid;
  logic        ready;
  logic [31:0] color;
  logic [2:0]  status;

  modport source (output valid, output color, output status, input ready);
  modport sink (input valid, input color, input status, output ready);
endinterface

/* design/csp_char_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_char_step
// Next parse state for one character.
// ----------------------------------------------------------------------------
module csp_char_step (
  input  csp_pkg::parse_state_t cur,
  input  logic [7:0]            raw,
  output csp_pkg::parse_state_t nxt
);
  import csp_pkg::*;

  logic [7:0] c;
  logic [4:0] p;
  logic [3:0] dig;
  logic       dig_ok;
  logic       hex_take;

  assign c = fold(raw);
  assign p = cur.pos;

  always_comb begin
    if (c >= "0" && c <= "9") begin
      dig = 4'(c - "0");
      dig_ok = 1'b1;
    end else if (c >= "a" && c <= "f") begin
      dig = 4'(c - "a" + 8'd10);
      dig_ok = 1'b1;
    end else begin
      dig = 4'd0;
      dig_ok = 1'b0;
    end
  end

  always_comb begin
    nxt = cur;
    hex_take = 1'b0;

    if (p >= EXACT_LEN || raw != char_at11(EXACT_TEXT, p[3:0])) begin
      nxt.exact = 1'b0;
    end

    case (cur.mode)
      MODE_START: begin
        if (c == "#") begin
          nxt.mode = MODE_HASH;
        end else if (c == "0") begin
          nxt.mode = MODE_ZERO;
        end else begin
          nxt.mode = MODE_NAME;
          nxt.cand = filter_names(CAND_BARE, 5'd0, c);
        end
      end
      MODE_NAME: nxt.cand = filter_names(cur.cand, p, c);
      MODE_HASH: begin
        if (p < PREFIX_LEN && c == char_at9(NS_PREFIX, p[3:0])) begin
          if (p == PREFIX_LEN - 5'd1) begin
            nxt.mode = MODE_PREFIX;
            nxt.cand = CAND_ALL;
          end else begin
            hex_take = 1'b1;  // prefix chars still feed the hex path
          end
        end else begin
          nxt.mode = MODE_HEX;
          hex_take = 1'b1;
        end
      end
      MODE_ZERO: nxt.mode = (p == 5'd1 && c == "x") ? MODE_HEX : MODE_DEAD;
      MODE_HEX: hex_take = 1'b1;
      MODE_PREFIX: nxt.cand = filter_names(cur.cand, p - PREFIX_LEN, c);
      MODE_DEAD: ;
      default: ;
    endcase

    if (hex_take) begin
      nxt.acc = {cur.acc[27:0], dig};
      nxt.bad = cur.bad | ~dig_ok;
      if (cur.digits != DIGITS_MAX) nxt.digits = cur.digits + 4'd1;
    end

    if (p != POS_MAX) nxt.pos = p + 5'd1;
  end

endmodule

/* design/csp_result.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_result
// Final color and status from the parse state at end of string.
// ----------------------------------------------------------------------------
module csp_result (
  input  csp_pkg::parse_state_t st,
  output logic [31:0]           color,
  output csp_pkg::status_t      status
);
  import csp_pkg::*;

  name_hit_t pre_hit;
  name_hit_t bare_hit;

  assign pre_hit  = find_name(st.cand, st.pos - PREFIX_LEN);
  assign bare_hit = find_name(st.cand & CAND_BARE, st.pos);

  always_comb begin
    color = '0;
    status = ST_OK;
    if (st.pos == 5'd0) begin
      status = ST_EMPTY;
    end else if (st.exact && st.pos == EXACT_LEN) begin
      color = '0;
    end else begin
      case (st.mode)
        MODE_PREFIX: begin
          if (pre_hit.hit) color = pre_hit.color;
          else status = ST_BAD_NAME;
        end
        MODE_HASH, MODE_HEX: begin
          if (st.digits != 4'd3 && st.digits != 4'd6 && st.digits != 4'd8) begin
            status = ST_BAD_LEN;
          end else if (st.bad) begin
            status = ST_BAD_DIGIT;
          end else if (st.digits == 4'd3) begin
            // nibble * 17 is the nibble repeated
            color = {8'hFF, st.acc[11:8], st.acc[11:8], st.acc[7:4], st.acc[7:4],
                     st.acc[3:0], st.acc[3:0]};
          end else if (st.digits == 4'd6) begin
            color = {8'hFF, st.acc[23:0]};
          end else begin
            color = st.acc;
          end
        end
        MODE_NAME: begin
          if (bare_hit.hit) color = bare_hit.color;
          else status = ST_UNKNOWN;
        end
        default: status = ST_UNKNOWN;
      endcase
    end
  end

endmodule

/* design/color_string_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_string_parser_unit
// Streaming parser of color strings into 32-bit AARRGGBB values.
// ----------------------------------------------------------------------------
// Feed one string byte per beat on char_stream; the beat with last set closes
// the string and produces exactly one beat on color_result (color plus
// status), other beats produce nothing. A beat with char_present low adds no
// character, so a lone such beat with last set reports an empty string.
// Throughput is one beat per cycle unless color_result stalls; the state
// update per character (prefix and name compares against constant tables,
// hex shift) is combinational from the input register to the parse state.
// A last beat goes through the input register, then the result register;
// as both are registers, char_stream keeps accepting while a result waits to
// be taken, stalling only with the input register full. No clear after reset.
// ----------------------------------------------------------------------------
module color_string_parser_unit (
  input logic      clk,
  input logic      rst,
  csp_char_if.sink    char_stream,
  csp_color_if.source color_result
);
  import csp_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_present;
  logic       in_last;

  // parse state carried across the string
  parse_state_t state;
  parse_state_t stepped;
  parse_state_t post;

  // result register
  logic        out_valid;
  logic [31:0] out_color;
  status_t     out_status;

  logic [31:0] fin_color;
  status_t     fin_status;
  logic        advance;

  // The processing stage moves whenever the result register is free or drains.
  assign advance = !out_valid || color_result.ready;
  assign char_stream.ready = !in_valid || advance;

  csp_char_step u_step (
    .cur (state),
    .raw (in_char),
    .nxt (stepped)
  );

  // Empty beats leave the state alone.
  assign post = in_present ? stepped : state;

  csp_result u_result (
    .st     (post),
    .color  (fin_color),
    .status (fin_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= reset_state();
    end else begin
      if (char_stream.ready) begin
        in_valid <= char_stream.valid;
        if (char_stream.valid) begin
          in_char    <= char_stream.char_code;
          in_present <= char_stream.char_present;
          in_last    <= char_stream.last;
        end
      end
      if (advance) begin
        out_valid <= in_valid && in_last;
        if (in_valid) begin
          // every string starts from the reset state
          state <= in_last ? reset_state() : post;
          if (in_last) begin
            out_color  <= fin_color;
            out_status <= fin_status;
          end
        end
      end
    end
  end

  assign color_result.valid  = out_valid;
  assign color_result.color  = out_color;
  assign color_result.status = out_status;

endmodule

/* test/color_string_parser_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_string_parser_unit_test
// Self-checking bench for the color string parser. Strings go in one byte per
// beat on the character channel. A behavioral parser inside the bench tracks
// every accepted beat and queues the color and status that each closing beat
// must give. Results are checked in order on the color channel. The directed
// strings come first, then random strings under changing backpressure.
// ----------------------------------------------------------------------------
module color_string_parser_unit_test;
  import csp_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 8;    // extra wait after the last result is taken

  // Namespace prefix bytes, lowercase; kept as codes rather than a literal.
  localparam logic [71:0] NS_TAG = {
    8'h23, 8'h61, 8'h6E, 8'h64, 8'h72, 8'h6F, 8'h69, 8'h64, 8'h3A
  };

  typedef struct packed {
    logic [31:0] color;
    status_t     status;
  } color_beat_t;

  logic clk;
  logic rst;

  csp_char_if  char_if ();
  csp_color_if color_if ();

  color_string_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .char_stream  (char_if),
    .color_result (color_if)
  );

  // Expected results, oldest first.
  color_beat_t pending_colors [$];
  // String under construction; sent in one go by send_buffer.
  logic [7:0]  str_buf [$];
  bit          end_with_blank;

  int unsigned fault_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Parser state as the bench sees it.
  mode_t       pm;
  logic [4:0]  ppos;
  logic [3:0]  ndigits;
  logic [31:0] hex_acc;
  logic [8:0]  cands;
  logic        exact_tr;
  logic        bad_digit;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Name tables
  // --------------------------------------------------------------------------
  function automatic string color_word(int i);
    case (i)
      0: return "red";
      1: return "green";
      2: return "blue";
      3: return "black";
      4: return "white";
      5: return "cyan";
      6: return "magenta";
      7: return "yellow";
      default: return "transparent";
    endcase
  endfunction

  function automatic logic [31:0] color_argb(int i);
    case (i)
      0: return 32'hFFFF0000;
      1: return 32'hFF00FF00;
      2: return 32'hFF0000FF;
      3: return 32'hFF000000;
      4: return 32'hFFFFFFFF;
      5: return 32'hFF00FFFF;
      6: return 32'hFFFF00FF;
      7: return 32'hFFFFFF00;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [7:0] ns_char(int k);
    return NS_TAG[71 - 8*k -: 8];
  endfunction

  // --------------------------------------------------------------------------
  // Behavioral parser
  // --------------------------------------------------------------------------
  function automatic logic [7:0] lower_char(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Keep only the names that have character c at position k.
  function automatic logic [8:0] narrow_names(logic [8:0] cand, int k, logic [7:0] c);
    logic [8:0] keep;
    string w;
    keep = cand;
    for (int i = 0; i < 9; i++) begin
      w = color_word(i);
      if (k >= w.len()) keep[i] = 1'b0;
      else if (w[k] != c) keep[i] = 1'b0;
    end
    return keep;
  endfunction

  // Lowest-index surviving name of the given length, -1 if none.
  function automatic int match_name(logic [8:0] cand, int count);
    string w;
    for (int i = 0; i < 9; i++) begin
      w = color_word(i);
      if (cand[i] && w.len() == count) return i;
    end
    return -1;
  endfunction

  task automatic clear_parse();
    pm = MODE_START;
    ppos = '0;
    ndigits = '0;
    hex_acc = '0;
    cands = 9'h1FF;
    exact_tr = 1'b1;
    bad_digit = 1'b0;
  endtask

  task automatic shift_hex(logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= "0" && c <= "9") d = 4'(c - "0");
    else if (c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
    else bad_digit = 1'b1;
    hex_acc = {hex_acc[27:0], d};
    if (ndigits < 4'd15) ndigits = ndigits + 4'd1;
  endtask

  task automatic absorb_char(logic [7:0] raw);
    int p;
    logic [7:0] c;
    string tw;
    p = int'(ppos);
    c = lower_char(raw);
    tw = color_word(8);
    // exact match is case sensitive, so compare the raw byte
    if (p >= 11) exact_tr = 1'b0;
    else if (raw != tw[p]) exact_tr = 1'b0;
    case (pm)
      MODE_START: begin
        if (c == "#") pm = MODE_HASH;
        else if (c == "0") pm = MODE_ZERO;
        else begin
          pm = MODE_NAME;
          cands = narrow_names(9'h0FF, 0, c);
        end
      end
      MODE_NAME: cands = narrow_names(cands, p, c);
      MODE_HASH: begin
        // still on the namespace prefix; prefix chars also count as hex
        if (p < 9 && c == ns_char(p)) begin
          if (p == 8) begin
            pm = MODE_PREFIX;
            cands = 9'h1FF;
          end else begin
            shift_hex(c);
          end
        end else begin
          pm = MODE_HEX;
          shift_hex(c);
        end
      end
      MODE_ZERO: begin
        if (p == 1 && c == "x") pm = MODE_HEX;
        else pm = MODE_DEAD;
      end
      MODE_HEX: shift_hex(c);
      MODE_PREFIX: cands = narrow_names(cands, p - 9, c);
      default: ;
    endcase
    if (ppos < 5'd31) ppos = ppos + 5'd1;
  endtask

  task automatic finish_string(output color_beat_t r);
    int idx;
    int n;
    r.color = 32'h0;
    r.status = ST_OK;
    n = int'(ndigits);
    if (ppos == 5'd0) begin
      r.status = ST_EMPTY;
    end else if (exact_tr && ppos == 5'd11) begin
      r.color = 32'h0;
    end else if (pm == MODE_PREFIX) begin
      idx = match_name(cands, int'(ppos) - 9);
      if (idx >= 0) r.color = color_argb(idx);
      else r.status = ST_BAD_NAME;
    end else if (pm == MODE_HASH || pm == MODE_HEX) begin
      if (n != 3 && n != 6 && n != 8) r.status = ST_BAD_LEN;
      else if (bad_digit) r.status = ST_BAD_DIGIT;
      else if (n == 3)
        // each nibble doubled: x * 17 == {x, x}
        r.color = {8'hFF, {2{hex_acc[11:8]}}, {2{hex_acc[7:4]}}, {2{hex_acc[3:0]}}};
      else if (n == 6) r.color = {8'hFF, hex_acc[23:0]};
      else r.color = hex_acc;
    end else if (pm == MODE_NAME) begin
      idx = match_name(cands & 9'h0FF, int'(ppos));
      if (idx >= 0) r.color = color_argb(idx);
      else r.status = ST_UNKNOWN;
    end else begin
      r.status = ST_UNKNOWN;
    end
    clear_parse();
  endtask

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(logic [7:0] code, logic present, logic lst);
    color_beat_t r;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk);
    end
    char_if.valid        <= 1'b1;
    char_if.char_code    <= code;
    char_if.char_present <= present;
    char_if.last         <= lst;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    if (present) absorb_char(code);
    if (lst) begin
      finish_string(r);
      pending_colors.push_back(r);
    end
  endtask

  // Sends str_buf as one string, with the odd blank beat mixed in.
  task automatic send_buffer();
    int n;
    n = str_buf.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < 4)
        send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      send_item(str_buf[i], 1'b1, (i == n - 1) && !end_with_blank);
    end
    if (n == 0 || end_with_blank)
      send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
    end_with_blank = 1'b0;
  endtask

  function automatic logic [7:0] jumble_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1, 0) == 1) return c - 8'd32;
    return c;
  endfunction

  task automatic push_word(string s, bit mixed);
    logic [7:0] b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      str_buf.push_back(mixed ? jumble_case(b) : b);
    end
  endtask

  task automatic push_prefix(bit mixed);
    for (int k = 0; k < 9; k++)
      str_buf.push_back(mixed ? jumble_case(ns_char(k)) : ns_char(k));
  endtask

  task automatic send_text(string s);
    str_buf.delete();
    push_word(s, 1'b0);
    send_buffer();
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  task automatic note_fault(string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  always @(posedge clk) begin
    color_beat_t want;
    if (rst) begin
      color_if.ready <= 1'b0;
    end else begin
      color_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (color_if.valid && color_if.ready) begin
        if (pending_colors.size() == 0) begin
          note_fault($sformatf("unexpected result color %08h status %0d",
                               color_if.color, color_if.status));
        end else begin
          want = pending_colors.pop_front();
          if (color_if.color !== want.color)
            note_fault($sformatf("color mismatch: expected %08h actual %08h",
                                 want.color, color_if.color));
          if (color_if.status !== want.status)
            note_fault($sformatf("status mismatch: expected %0d actual %0d",
                                 want.status, color_if.status));
        end
      end
    end
  end

  // Watchdog: the run is stuck if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((char_if.valid && char_if.ready) || (color_if.valid && color_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_strings();
    send_item(8'h00, 1'b0, 1'b1);       // lone blank beat closes an empty string
    str_buf.delete();
    push_word("red", 1'b0);
    end_with_blank = 1'b1;              // blank closing beat after real chars
    send_buffer();
  endtask

  task automatic test_exact_transparent();
    send_text("transparent");
    send_text("Transparent");           // folds to a bare name, which excludes it
  endtask

  task automatic test_prefixed_names();
    for (int i = 0; i < 9; i++) begin
      str_buf.delete();
      push_prefix(i[0]);
      push_word(color_word(i), i[1]);
      send_buffer();
    end
    str_buf.delete();
    push_prefix(1'b0);
    push_word("purple", 1'b0);
    send_buffer();
    str_buf.delete();
    push_prefix(1'b1);                  // prefix with no name
    send_buffer();
  endtask

  task automatic test_hex_colors();
    send_text("#f0a");
    send_text("#123456");
    send_text("0x89ABCDEF");
    send_text("0XFFFFFFFF");
    send_text("#12345");
    send_text("#12g");
    send_text("#");
    send_text("#add");                  // leaves the prefix early, hex from 'a'
    send_text("0x");
    send_text("0xg12");
    send_text("0");
    send_text("07");
  endtask

  task automatic test_bare_names();
    for (int i = 0; i < 8; i++) begin
      str_buf.delete();
      push_word(color_word(i), i[0]);
      send_buffer();
    end
    send_text("blu");
  endtask

  task automatic test_odd_bytes();
    str_buf.delete();
    push_word("gr", 1'b0);
    str_buf.push_back(8'hFF);           // non-ASCII is never folded
    push_word("en", 1'b0);
    send_buffer();
    str_buf.delete();
    str_buf.push_back(8'h00);
    send_buffer();
    str_buf.delete();
    str_buf.push_back(8'h80);
    send_buffer();
    // position and digit counters saturate on long strings
    str_buf.delete();
    push_word("#", 1'b0);
    for (int i = 0; i < 33; i++) push_word("f", 1'b0);
    send_buffer();
    str_buf.delete();
    for (int i = 0; i < 12; i++) push_word("red", 1'b0);
    send_buffer();
    str_buf.delete();
    push_prefix(1'b0);
    for (int i = 0; i < 25; i++) push_word("a", 1'b0);
    send_buffer();
  endtask

  task automatic build_random_string();
    int kind;
    int n;
    string pool;
    pool = "0123456789abcdefABCDEF";
    str_buf.delete();
    kind = $urandom_range(99, 0);
    if (kind < 6) begin
      push_word("transparent", $urandom_range(3, 0) == 0);
    end else if (kind < 26) begin
      push_prefix(1'($urandom_range(1, 0)));
      push_word(color_word($urandom_range(8, 0)), 1'($urandom_range(1, 0)));
    end else if (kind < 56) begin
      case ($urandom_range(2, 0))
        0: push_word("#", 1'b0);
        1: push_word("0x", 1'b0);
        default: push_word("0X", 1'b0);
      endcase
      if ($urandom_range(9, 0) < 7) begin
        case ($urandom_range(2, 0))
          0: n = 3;
          1: n = 6;
          default: n = 8;
        endcase
      end else begin
        n = $urandom_range(18, 0);
      end
      for (int i = 0; i < n; i++) str_buf.push_back(pool[$urandom_range(21, 0)]);
    end else if (kind < 76) begin
      push_word(color_word($urandom_range(8, 0)), 1'($urandom_range(1, 0)));
    end else begin
      // noise, now and then long enough to saturate the position
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
      if ($urandom_range(3, 0) == 0) push_word($urandom_range(1, 0) ? "#" : "0", 1'b0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1, 0) == 1) str_buf.push_back(8'($urandom_range(255, 0)));
        else str_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
      end
    end
    // break some well-formed strings
    if (str_buf.size() > 0 && $urandom_range(99, 0) < 15)
      str_buf[$urandom_range(str_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
    if (str_buf.size() > 0 && $urandom_range(99, 0) < 8) void'(str_buf.pop_back());
    if ($urandom_range(99, 0) < 5) str_buf.push_back(8'($urandom_range(255, 0)));
    end_with_blank = ($urandom_range(99, 0) < 10);
  endtask

  task automatic test_random_strings(int unsigned char_budget);
    int unsigned sent;
    sent = 0;
    while (sent < char_budget) begin
      build_random_string();
      sent += str_buf.size();
      send_buffer();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_parse();
    fault_count = 0;
    end_with_blank = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 70;
    rst                  <= 1'b1;
    char_if.valid        <= 1'b0;
    char_if.char_code    <= 8'h00;
    char_if.char_present <= 1'b0;
    char_if.last         <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_strings();
    test_exact_transparent();
    test_prefixed_names();
    test_hex_colors();
    test_bare_names();
    test_odd_bytes();

    // backpressure phases: slow receiver, slow sender, then full rate
    test_random_strings(15);
    send_idle_pct = 70;
    recv_idle_pct = 10;
    test_random_strings(15);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(15);

    char_if.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && pending_colors.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
